// ----- hw/rtl/csnn_pkg.sv -----
// shared types and constants for the chi-square nearest neighbour block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csnn_pkg;
    localparam int MAX_TRAIN    = 256;
    localparam int MAX_DIM      = 256;
    localparam int FEATURE_BITS = 16;
    localparam int FRAC_BITS    = 8;
    localparam int TI_W   = $clog2(MAX_TRAIN);
    localparam int EI_W   = $clog2(MAX_DIM);
    localparam int CFG_W  = 9;
    localparam int ACC_W  = 48;
    localparam int CNT_W  = 16;
    localparam int LAB_W  = 8;
    localparam int SQ_W   = 2 * FEATURE_BITS;
    localparam int SUM_W  = FEATURE_BITS + 1;
    localparam int NUM_W  = SQ_W + FRAC_BITS;
    localparam int QDEPTH = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;
    localparam logic CFG_DIM = 1'b0;
    localparam logic CFG_NTR = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [TI_W-1:0]         vi;
        logic [EI_W-1:0]         ei;
        logic [FEATURE_BITS-1:0] fv;
        logic [LAB_W-1:0]        lab;
        logic                    first;
        logic                    last;
        logic [TI_W:0]           n_use;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE, S_RUN, S_DRAIN, S_SCAN
    } state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/csnn_front.sv -----
// front: classifies beats and queues loads and test beats in arrival order
// depends on csnn_pkg
`timescale 1ns / 1ps
`default_nettype none
module csnn_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              operation,
    input  wire logic [7:0]                        vector_index,
    input  wire logic [7:0]                        element_index,
    input  wire logic [15:0]                       feature_value,
    input  wire logic [7:0]                        label,
    input  wire logic [csnn_pkg::CFG_W-1:0]        dim_reg,
    input  wire logic [csnn_pkg::CFG_W-1:0]        ntr_reg,
    output logic                                   q_valid,
    output csnn_pkg::cmd_t                         q_cmd,
    input  wire logic                              q_take
);
    localparam int AW = $clog2(csnn_pkg::QDEPTH);
    csnn_pkg::cmd_t q_mem [csnn_pkg::QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic [csnn_pkg::CFG_W-1:0] d_use, n_use;
    logic acc, keep;
    csnn_pkg::cmd_t c;

    always_comb
    begin
        d_use = (dim_reg == '0) ? csnn_pkg::CFG_W'(1)
              : (dim_reg > csnn_pkg::CFG_W'(csnn_pkg::MAX_DIM))
                ? csnn_pkg::CFG_W'(csnn_pkg::MAX_DIM) : dim_reg;
        n_use = (ntr_reg == '0) ? csnn_pkg::CFG_W'(1)
              : (ntr_reg > csnn_pkg::CFG_W'(csnn_pkg::MAX_TRAIN))
                ? csnn_pkg::CFG_W'(csnn_pkg::MAX_TRAIN) : ntr_reg;
    end

    assign full = (cnt_reg == (AW+1)'(csnn_pkg::QDEPTH));
    assign acc  = push && !full;
    // loads always queue, test beats beyond dim are dropped
    assign keep = (operation == csnn_pkg::OP_LOAD)
               || (csnn_pkg::CFG_W'(element_index) < d_use);

    always_comb
    begin
        c.op    = operation;
        c.vi    = vector_index[csnn_pkg::TI_W-1:0];
        c.ei    = element_index[csnn_pkg::EI_W-1:0];
        c.fv    = feature_value;
        c.lab   = label;
        c.first = (element_index == 8'd0);
        c.last  = (csnn_pkg::CFG_W'(element_index) == d_use - csnn_pkg::CFG_W'(1));
        c.n_use = n_use[csnn_pkg::TI_W:0];
    end

    always_ff @(posedge clk)
    begin
        if (acc && keep)
            q_mem[wp_reg] <= c;
    end

    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = q_mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (acc && keep)
                wp_reg <= wp_reg + AW'(1);
            if (q_take)
                rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(acc && keep) - (AW+1)'(q_take);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_valid)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(csnn_pkg::QDEPTH))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) == cnt_reg[AW-1:0])
        else $error("queue pointers out of step with count");
endmodule
`default_nettype wire

// ----- hw/rtl/csnn_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on csnn_pkg
`timescale 1ns / 1ps
`default_nettype none
module csnn_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [csnn_pkg::NUM_W-1:0]    num,
    input  wire logic [csnn_pkg::SUM_W-1:0]    den,
    input  wire logic [csnn_pkg::TI_W-1:0]     tag,
    output logic                               out_valid,
    output logic [csnn_pkg::NUM_W-1:0]         quo,
    output logic [csnn_pkg::TI_W-1:0]          out_tag
);
    localparam int N = csnn_pkg::NUM_W;
    localparam int D = csnn_pkg::SUM_W;
    logic [N:0]             v_reg;
    logic [N-1:0]           q_reg [N+1];
    logic [D:0]             r_reg [N+1];
    logic [D-1:0]           d_reg [N+1];
    logic [csnn_pkg::TI_W-1:0] t_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= num;
        r_reg[0] <= '0;
        d_reg[0] <= den;
        t_reg[0] <= tag;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_st
        logic [D:0] sh;
        logic [N-1:0] qs;
        always_comb
        begin
            sh = {r_reg[k][D-1:0], q_reg[k][N-1]};
            qs = {q_reg[k][N-2:0], 1'b0};
        end
        always_ff @(posedge clk)
        begin
            if (sh >= {1'b0, d_reg[k]})
            begin
                r_reg[k+1] <= sh - {1'b0, d_reg[k]};
                q_reg[k+1] <= qs | N'(1);
            end
            else
            begin
                r_reg[k+1] <= sh;
                q_reg[k+1] <= qs;
            end
            d_reg[k+1] <= d_reg[k];
            t_reg[k+1] <= t_reg[k];
        end
    end

    assign out_valid = v_reg[N];
    assign quo       = q_reg[N];
    assign out_tag   = t_reg[N];
endmodule
`default_nettype wire

// ----- hw/rtl/csnn_back.sv -----
// back: store, per-slot chi-square terms, accumulators, arg-min scan and result
// depends on csnn_pkg, csnn_div
`timescale 1ns / 1ps
`default_nettype none
module csnn_back (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_valid,
    input  csnn_pkg::cmd_t                              q_cmd,
    output logic                                        q_take,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic [7:0]                                  predicted_index,
    output logic [7:0]                                  predicted_label,
    output logic                                        is_correct,
    output logic [47:0]                                 best_distance,
    output logic [15:0]                                 correct_count,
    output logic [15:0]                                 test_count
);
    localparam int TW = csnn_pkg::TI_W;
    localparam int AW = csnn_pkg::ACC_W;
    localparam logic [AW-1:0] AMAX = '1;

    logic [csnn_pkg::FEATURE_BITS-1:0] store_mem [csnn_pkg::MAX_TRAIN*csnn_pkg::MAX_DIM];
    logic [csnn_pkg::LAB_W-1:0]        lab_mem [csnn_pkg::MAX_TRAIN];
    logic [AW-1:0]                     acc_mem [csnn_pkg::MAX_TRAIN];

    csnn_pkg::state_t state_reg, state_next;
    csnn_pkg::cmd_t   cmd_reg;
    logic [TW:0]      j_reg;
    logic             rd_v_reg, sq_v_reg;
    logic [csnn_pkg::FEATURE_BITS-1:0] y_reg;
    logic [TW-1:0]    rd_t_reg, sq_t_reg;
    logic [csnn_pkg::SQ_W-1:0] sq_reg;
    logic [csnn_pkg::SUM_W-1:0] s_reg;
    logic [csnn_pkg::SUM_W-1:0] s_reg_n;
    logic [csnn_pkg::FEATURE_BITS-1:0] dif_n;
    logic             take_ok, ld_cmd, run_cmd, issue;
    logic             dv;
    logic [csnn_pkg::NUM_W-1:0] quo;
    logic [TW-1:0]    dtag;
    logic [TW:0]      done_reg;
    logic             a_v_reg;
    logic [TW-1:0]    a_t_reg;
    logic [AW-1:0]    a_reg, term_reg;
    logic [AW:0]      a_sum;
    logic [csnn_pkg::MAX_TRAIN-1:0] clr_reg;
    logic             sc_rd, sc_v_reg, sc_last_reg;
    logic [TW-1:0]    sc_t_reg;
    logic [AW-1:0]    sc_d_reg, best_d_reg;
    logic [TW-1:0]    best_i_reg;
    logic             fin_reg, fin2_reg;
    logic [csnn_pkg::LAB_W-1:0] bl_reg;
    logic [15:0]      cc_reg, tc_reg;
    logic             res_v_reg;
    logic             ok_w;

    // a waiting result holds back only a last element
    assign take_ok = q_valid && ((q_cmd.op == csnn_pkg::OP_LOAD) || !q_cmd.last
                                 || !res_v_reg);

    always_ff @(posedge clk)
    begin
        if (ld_cmd && (q_cmd.op == csnn_pkg::OP_LOAD))
        begin
            store_mem[{q_cmd.vi, q_cmd.ei}] <= q_cmd.fv;
            lab_mem[q_cmd.vi] <= q_cmd.lab;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csnn_pkg::S_IDLE:  if (take_ok && (q_cmd.op == csnn_pkg::OP_TEST))
                                   state_next = csnn_pkg::S_RUN;
            csnn_pkg::S_RUN:   if (j_reg == cmd_reg.n_use - (TW+1)'(1))
                                   state_next = csnn_pkg::S_DRAIN;
            csnn_pkg::S_DRAIN: if (done_reg == cmd_reg.n_use && !a_v_reg)
                                   state_next = cmd_reg.last ? csnn_pkg::S_SCAN
                                                             : csnn_pkg::S_IDLE;
            csnn_pkg::S_SCAN:  if (fin2_reg) state_next = csnn_pkg::S_IDLE;
            default:           state_next = csnn_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ld_cmd = 1'b0;
        issue  = 1'b0;
        sc_rd  = 1'b0;
        unique case (state_reg)
            csnn_pkg::S_IDLE:  ld_cmd = take_ok;
            csnn_pkg::S_RUN:   issue = 1'b1;
            csnn_pkg::S_DRAIN: ;
            csnn_pkg::S_SCAN:  sc_rd = (j_reg < cmd_reg.n_use);
            default: ;
        endcase
    end
    assign q_take  = ld_cmd;
    assign run_cmd = ld_cmd && (q_cmd.op == csnn_pkg::OP_TEST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= csnn_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (run_cmd)
            cmd_reg <= q_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_reg <= '0;
        else if (ld_cmd || (state_reg == csnn_pkg::S_DRAIN))
            j_reg <= '0;
        else if (issue || sc_rd)
            j_reg <= j_reg + (TW+1)'(1);
    end

    // stage 1: store read
    always_ff @(posedge clk)
    begin
        y_reg    <= store_mem[{j_reg[TW-1:0], cmd_reg.ei}];
        rd_t_reg <= j_reg[TW-1:0];
    end

    // stage 2: square and sum
    always_comb
    begin
        s_reg_n  = {1'b0, cmd_reg.fv} + {1'b0, y_reg};
        dif_n    = (cmd_reg.fv > y_reg) ? cmd_reg.fv - y_reg : y_reg - cmd_reg.fv;
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= dif_n * dif_n;
        s_reg    <= s_reg_n;
        sq_t_reg <= rd_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue;
            sq_v_reg <= rd_v_reg;
        end
    end

    csnn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_v_reg),
        .num       ({sq_reg, csnn_pkg::FRAC_BITS'(0)}),
        .den       ((s_reg == '0) ? csnn_pkg::SUM_W'(1) : s_reg),
        .tag       (sq_t_reg),
        .out_valid (dv),
        .quo       (quo),
        .out_tag   (dtag)
    );
    // zero sum means zero square, so quotient is zero as required

    // cleared slots read as zero until their first write after element zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '1;
        else if (run_cmd && q_cmd.first)
            clr_reg <= '1;
        else if (a_v_reg)
            clr_reg[a_t_reg] <= 1'b0;
    end

    // accumulate: read then write back, slots never repeat within a beat
    always_ff @(posedge clk)
    begin
        a_reg    <= clr_reg[dtag] ? '0 : acc_mem[dtag];
        term_reg <= AW'(quo);
        a_t_reg  <= dtag;
        if (a_v_reg)
            acc_mem[a_t_reg] <= a_sum[AW] ? AMAX : a_sum[AW-1:0];
        sc_d_reg <= acc_mem[j_reg[TW-1:0]];
        sc_t_reg <= j_reg[TW-1:0];
    end
    assign a_sum = {1'b0, a_reg} + {1'b0, term_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            done_reg <= '0;
        end
        else
        begin
            a_v_reg <= dv;
            if (ld_cmd)
                done_reg <= '0;
            else if (a_v_reg)
                done_reg <= done_reg + (TW+1)'(1);
        end
    end

    // arg-min scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_v_reg    <= 1'b0;
            sc_last_reg <= 1'b0;
            fin_reg     <= 1'b0;
            fin2_reg    <= 1'b0;
        end
        else
        begin
            sc_v_reg    <= sc_rd;
            sc_last_reg <= sc_rd && (j_reg == cmd_reg.n_use - (TW+1)'(1));
            fin_reg     <= sc_v_reg && sc_last_reg;
            fin2_reg    <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_v_reg && (sc_t_reg == '0 || sc_d_reg < best_d_reg))
        begin
            best_d_reg <= sc_d_reg;
            best_i_reg <= sc_t_reg;
        end
        bl_reg <= lab_mem[best_i_reg];
    end

    // bl_reg holds the final label while fin2_reg is high
    always_comb
        ok_w = (bl_reg == cmd_reg.lab);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
            cc_reg    <= '0;
            tc_reg    <= '0;
        end
        else
        begin
            if (fin2_reg)
            begin
                res_v_reg <= 1'b1;
                if (tc_reg != '1)
                    tc_reg <= tc_reg + 16'd1;
                if (ok_w && cc_reg != '1)
                    cc_reg <= cc_reg + 16'd1;
            end
            else if (pop && res_v_reg)
                res_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin2_reg)
        begin
            predicted_index <= 8'(best_i_reg);
            predicted_label <= bl_reg;
            is_correct      <= ok_w;
            best_distance   <= best_d_reg;
        end
    end

    assign empty         = !res_v_reg;
    assign correct_count = cc_reg;
    assign test_count    = tc_reg;

    assert property (@(posedge clk) disable iff (!rst_n) fin2_reg |-> !res_v_reg)
        else $error("result overwritten");
    assert property (@(posedge clk) disable iff (!rst_n) cc_reg <= tc_reg || tc_reg == '1)
        else $error("correct count passed test count");
    assert property (@(posedge clk) disable iff (!rst_n)
        ld_cmd |-> (state_reg == csnn_pkg::S_IDLE))
        else $error("command taken while busy");
endmodule
`default_nettype wire

// ----- hw/rtl/chi_square_nearest_neighbor.sv -----
// top level of the chi-square one-nearest-neighbour classifier
// depends on csnn_pkg, csnn_front, csnn_back
`timescale 1ns / 1ps
`default_nettype none
// Loads and test elements share a four-entry queue, so they are carried out
// in arrival order; a load is written into the store when the back takes it.
// A test element passes one slot per cycle through the store read, the
// squarer and a 40-stage divider, then a drain; the last element adds an
// arg-min scan, and waits while an earlier result is still unread. The queue
// decouples the front from the back.
module chi_square_nearest_neighbor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [7:0]  vector_index,
    input  wire logic [7:0]  element_index,
    input  wire logic [15:0] feature_value,
    input  wire logic [7:0]  label,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       predicted_index,
    output logic [7:0]       predicted_label,
    output logic             is_correct,
    output logic [47:0]      best_distance,
    output logic [15:0]      correct_count,
    output logic [15:0]      test_count,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);
    logic [csnn_pkg::CFG_W-1:0] dim_reg, ntr_reg;
    logic q_valid, q_take;
    csnn_pkg::cmd_t q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 9'd256;
            ntr_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            if (cfg_index == csnn_pkg::CFG_DIM)
                dim_reg <= cfg_data;
            else
                ntr_reg <= cfg_data;
        end
    end

    csnn_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .vector_index(vector_index),
        .element_index(element_index), .feature_value(feature_value),
        .label(label), .dim_reg(dim_reg), .ntr_reg(ntr_reg),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
    );

    csnn_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid),
        .q_cmd(q_cmd), .q_take(q_take), .empty(empty), .pop(pop),
        .predicted_index(predicted_index), .predicted_label(predicted_label),
        .is_correct(is_correct), .best_distance(best_distance),
        .correct_count(correct_count), .test_count(test_count)
    );
endmodule
`default_nettype wire
